[sv/kci_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_pkg
// Shared constants, types and codes for the keyframe curve interpolator.
// ----------------------------------------------------------------------------
package kci_pkg;

  localparam int unsigned MaxKeys = 64;
  localparam int unsigned IdxW    = $clog2(MaxKeys);
  localparam int unsigned CntW    = $clog2(MaxKeys + 1);
  localparam int unsigned KeyW    = 64;  // time in the upper half, value in the lower

  typedef enum logic [2:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_OVERWRITE = 3'd1,
    STATUS_DROPPED   = 3'd2,
    STATUS_EVALUATED = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SET_DEC,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_EV_RD,
    ST_EV_CHK,
    ST_DIV,
    ST_MUL0,
    ST_MUL1,
    ST_SUM,
    ST_DONE
  } state_e;

endpackage

[sv/kci_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module kci_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[sv/keyframe_curve_interpolator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_curve_interpolator_core
// Sorted keyframe table in one RAM (time and value per entry), with set by
// binary search and insertion shift, and evaluate by linear interpolation.
//
//   channel  direction  signals
//   in       input      in_valid_i / in_ready_o, command_i, time_in_i, value_in_i
//   out      output     out_valid_o / out_ready_i, result_value_o, status_o,
//                       key_count_o
//
// One item at a time. Each search probe is a read then a compare, at most 7
// probes with 64 keys, plus 1 closing read. Overwrite or drop ends there.
// Insert adds a read and a write per shifted entry and 1 write of the new key.
// Evaluate adds a read of the key below, 17 division steps and a weighted sum
// of two products. The single RAM port serialises these reads and writes.
// Reset empties the table at once (count cleared); no clearing pass.
// A held result stalls the next item until it is transferred.
// ----------------------------------------------------------------------------
module keyframe_curve_interpolator_core
  import kci_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic signed [31:0] time_in_i,
  input  logic signed [31:0] value_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic [2:0]         status_o,
  output logic [6:0]         key_count_o
);

  state_e state_q, state_d;

  logic               cmd_q;
  logic signed [31:0] t_q, v_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    lo_q, lo_d, hi_q, hi_d, ptr_q, ptr_d;
  logic [KeyW-1:0]    hi_key_q, hi_key_d;
  logic signed [31:0] v0_q, v0_d;
  logic signed [31:0] res_q, res_d;
  status_e            status_q, status_d;
  logic [32:0]        rem_q, rem_d, den_q, den_d;
  logic [16:0]        quo_q, quo_d;
  logic [4:0]         dcnt_q, dcnt_d;
  logic signed [49:0] p0_q, p0_d, p1_q, p1_d;

  logic              ram_we;
  logic [IdxW-1:0]   ram_addr;
  logic [KeyW-1:0]   ram_wdata, ram_rdata;

  kci_ram #(.Width(KeyW), .Depth(MaxKeys)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  logic signed [31:0] rd_t, rd_v, hk_t, hk_v;
  assign rd_t = ram_rdata[63:32];
  assign rd_v = ram_rdata[31:0];
  assign hk_t = hi_key_q[63:32];
  assign hk_v = hi_key_q[31:0];

  logic [CntW-1:0] mid;
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // both differences are positive once the bracketing pair is found
  logic [32:0] num_w, den_w;
  assign num_w = {t_q[31], t_q} - {rd_t[31], rd_t};
  assign den_w = {hk_t[31], hk_t} - {rd_t[31], rd_t};

  logic        div_ge;
  logic [32:0] div_rem;
  assign div_ge  = (rem_q >= den_q);
  assign div_rem = div_ge ? (rem_q - den_q) : rem_q;

  // ratio of 1.0 is held at the largest Q0.16 value
  logic signed [17:0] w0, w1;
  assign w1 = quo_q[16] ? 18'sd65535 : $signed({2'b00, quo_q[15:0]});
  assign w0 = 18'sd65536 - w1;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    ptr_d    = ptr_q;
    hi_key_d = hi_key_q;
    v0_d     = v0_q;
    res_d    = res_q;
    status_d = status_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    den_d    = den_q;
    dcnt_d   = dcnt_q;
    p0_d     = p0_q;
    p1_d     = p1_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          lo_d  = '0;
          hi_d  = cnt_q;
          res_d = '0;
          if (command_i && cnt_q == '0) begin
            status_d = STATUS_EMPTY;
            state_d  = ST_DONE;
          end else begin
            state_d = ST_SRCH_RD;
          end
        end
      end
      ST_SRCH_RD: begin
        if (lo_q < hi_q) state_d = ST_SRCH_CMP;
        else if (cmd_q) state_d = ST_EV_RD;
        else state_d = ST_SET_DEC;
      end
      ST_SRCH_CMP: begin
        if (rd_t < t_q) lo_d = mid + CntW'(1);
        else hi_d = mid;
        state_d = ST_SRCH_RD;
      end
      ST_SET_DEC: begin
        // ram holds key at lo (read issued in search read state)
        if (lo_q < cnt_q && rd_t == t_q) begin
          status_d = STATUS_OVERWRITE;
          state_d  = ST_DONE;
        end else if (cnt_q >= CntW'(MaxKeys)) begin
          status_d = STATUS_DROPPED;
          state_d  = ST_DONE;
        end else begin
          ptr_d   = cnt_q;
          state_d = ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (ptr_q == lo_q) begin
          cnt_d    = cnt_q + CntW'(1);
          status_d = STATUS_INSERTED;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        ptr_d   = ptr_q - CntW'(1);
        state_d = ST_SHIFT_RD;
      end
      ST_EV_RD: begin
        // ram holds key[lo], the first key not below t
        status_d = STATUS_EVALUATED;
        hi_key_d = ram_rdata;
        if (lo_q == '0) begin
          res_d   = rd_v;
          state_d = ST_DONE;
        end else begin
          state_d = ST_EV_CHK;
        end
      end
      ST_EV_CHK: begin
        // ram holds key[lo-1], hi_key_q holds key[lo]
        if (lo_q == cnt_q) begin
          res_d   = rd_v;
          state_d = ST_DONE;
        end else if (lo_q == cnt_q - CntW'(1) && hk_t == t_q) begin
          res_d   = hk_v;
          state_d = ST_DONE;
        end else begin
          rem_d   = num_w;
          den_d   = den_w;
          quo_d   = '0;
          dcnt_d  = 5'd16;
          v0_d    = rd_v;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = {div_rem[31:0], 1'b0};
        quo_d  = {quo_q[15:0], div_ge};
        dcnt_d = dcnt_q - 5'd1;
        if (dcnt_q == '0) state_d = ST_MUL0;
      end
      ST_MUL0: begin
        p0_d    = 50'(v0_q * w0);
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        p1_d    = 50'(hk_v * w1);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        res_d   = 32'((p0_q + p1_q) >>> 16);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ram port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = {t_q, v_q};
    unique case (state_q)
      ST_SRCH_RD: begin
        if (lo_q < hi_q) ram_addr = IdxW'(mid);
        else ram_addr = IdxW'(lo_q);
      end
      ST_SET_DEC: begin
        if (lo_q < cnt_q && rd_t == t_q) begin
          ram_we   = 1'b1;
          ram_addr = IdxW'(lo_q);
        end
      end
      ST_SHIFT_RD: begin
        if (ptr_q == lo_q) begin
          ram_we   = 1'b1;
          ram_addr = IdxW'(lo_q);
        end else begin
          ram_addr = IdxW'(ptr_q - CntW'(1));
        end
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_addr  = IdxW'(ptr_q);
        ram_wdata = ram_rdata;
      end
      ST_EV_RD: begin
        ram_addr = IdxW'(lo_q - CntW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      cmd_q <= command_i;
      t_q   <= time_in_i;
      v_q   <= value_in_i;
    end
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    ptr_q    <= ptr_d;
    hi_key_q <= hi_key_d;
    v0_q     <= v0_d;
    res_q    <= res_d;
    status_q <= status_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    den_q    <= den_d;
    dcnt_q   <= dcnt_d;
    p0_q     <= p0_d;
    p1_q     <= p1_d;
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = (state_q == ST_DONE);
  assign result_value_o = res_q;
  assign status_o       = status_q;
  assign key_count_o    = 7'(cnt_q);

endmodule

[sv/kci_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_checker
// Port-level checks on the keyframe curve interpolator.
// ----------------------------------------------------------------------------
module kci_checker
  import kci_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [6:0]  key_count_o
);

  // one item in flight: no input transfer while a result is shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result changed under stall");

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_count_o <= 7'(MaxKeys)) else $error("count overflow");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_EMPTY |-> key_count_o == '0)
    else $error("empty status with keys");

endmodule

bind keyframe_curve_interpolator_core kci_checker u_kci_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .status_o   (status_o),
  .key_count_o(key_count_o)
);

[tb/sv/tb_keyframe_curve_interpolator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_curve_interpolator_core
// Drives set and evaluate commands into the keyframe interpolator, keeps its
// own sorted key table to work out each expected result, and compares every
// output transfer field by field, in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_keyframe_curve_interpolator_core;
  import kci_pkg::*;

  localparam logic CmdSet  = 1'b0;
  localparam logic CmdEval = 1'b1;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [31:0] value;
    logic        [6:0]  count;
  } curve_result_t;

  typedef struct {
    logic               cmd;
    logic signed [31:0] t;
    logic signed [31:0] v;
    logic               typed;
    curve_result_t      res;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               command_i = 1'b0;
  logic signed [31:0] time_in_i = '0;
  logic signed [31:0] value_in_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] result_value_o;
  logic [2:0]         status_o;
  logic [6:0]         key_count_o;

  keyframe_curve_interpolator_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .time_in_i, .value_in_i,
    .out_valid_o, .out_ready_i, .result_value_o, .status_o, .key_count_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // own copy of the key table
  logic signed [31:0] key_t[MaxKeys];
  logic signed [31:0] key_v[MaxKeys];
  int unsigned        n_keys = 0;

  curve_result_t      pending_q[$];
  curve_result_t      typed_q[$];
  logic               typed_valid_q[$];
  int                 n_errors = 0;
  int                 n_results = 0;
  int                 n_sent = 0;
  int                 n_interp = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;

  function automatic int unsigned first_not_below(logic signed [31:0] t);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = n_keys;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_t[mid] < t) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic signed [31:0] curve_at(logic signed [31:0] t);
    int unsigned        pos;
    longint             num, den, ratio, acc;
    if (t <= key_t[0]) return key_v[0];
    if (t >= key_t[n_keys-1]) return key_v[n_keys-1];
    pos = first_not_below(t);
    num = longint'(t) - longint'(key_t[pos-1]);
    den = longint'(key_t[pos]) - longint'(key_t[pos-1]);
    ratio = (num <<< 16) / den;
    if (ratio > 65535) ratio = 65535;
    acc = longint'(key_v[pos-1]) * (65536 - ratio) + longint'(key_v[pos]) * ratio;
    n_interp++;
    return 32'(acc >>> 16);  // arithmetic shift floors
  endfunction

  function automatic curve_result_t apply_command(logic cmd, logic signed [31:0] t,
                                                 logic signed [31:0] v);
    curve_result_t r;
    int unsigned   pos;
    r.value = '0;
    if (cmd == CmdSet) begin
      pos = first_not_below(t);
      if (pos < n_keys && key_t[pos] == t) begin
        key_v[pos] = v;
        r.status = STATUS_OVERWRITE;
      end else if (n_keys >= MaxKeys) begin
        r.status = STATUS_DROPPED;
      end else begin
        for (int unsigned i = n_keys; i > pos; i--) begin
          key_t[i] = key_t[i-1];
          key_v[i] = key_v[i-1];
        end
        key_t[pos] = t;
        key_v[pos] = v;
        n_keys++;
        r.status = STATUS_INSERTED;
      end
    end else if (n_keys == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.value = curve_at(t);
      r.status = STATUS_EVALUATED;
    end
    r.count = 7'(n_keys);
    return r;
  endfunction

  // called at a falling edge; valid drops only while the sender idles
  task automatic send_item(logic cmd, logic signed [31:0] t, logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    time_in_i  <= t;
    value_in_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.insert(pending_q.size(), apply_command(cmd, t, v));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_row(stim_row_t row);
    typed_valid_q.insert(typed_valid_q.size(), row.typed);
    typed_q.insert(typed_q.size(), row.res);
    send_item(row.cmd, row.t, row.v);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
  endtask

  // receiver
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    curve_result_t exp_r;
    logic          row_typed;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: value %0d status %0d",
               result_value_o, status_o);
        n_errors++;
      end else begin
        exp_r = pending_q.pop_front();
        // typed rows are checked against their typed values
        if (typed_valid_q.size() != 0) begin
          row_typed = typed_valid_q.pop_front();
          if (row_typed) exp_r = typed_q.pop_front();
          else void'(typed_q.pop_front());
        end
        if (result_value_o !== exp_r.value) begin
          $error("result_value: expected %0d, got %0d", exp_r.value, result_value_o);
          n_errors++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          n_errors++;
        end
        if (key_count_o !== exp_r.count) begin
          $error("key_count: expected %0d, got %0d", exp_r.count, key_count_o);
          n_errors++;
        end
      end
    end
  end

  function automatic stim_row_t mk(logic cmd, logic signed [31:0] t, logic signed [31:0] v,
                                   logic typed, logic [2:0] st, logic signed [31:0] rv,
                                   logic [6:0] cnt);
    stim_row_t r;
    r.cmd = cmd; r.t = t; r.v = v; r.typed = typed;
    r.res.status = st; r.res.value = rv; r.res.count = cnt;
    return r;
  endfunction

  // random time biased towards a small window so keys collide and bracket
  function automatic logic signed [31:0] rand_time();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed(32'($urandom_range(64))) - 32;
      default: return $signed(32'($urandom_range(32'h0010_0000))) - 32'sh0008_0000;
    endcase
  endfunction

  stim_row_t directed[$];

  initial begin
    directed.insert(directed.size(), mk(CmdEval, 32'sd5, 0, 1, STATUS_EMPTY, 0, 0));
    directed.insert(directed.size(), mk(CmdEval, 32'h8000_0000, 0, 1, STATUS_EMPTY, 0, 0));
    directed.insert(directed.size(),
                    mk(CmdSet, 32'sh0001_0000, 32'sh0002_0000, 1, STATUS_INSERTED, 0, 1));
    directed.insert(directed.size(),
                    mk(CmdEval, 32'h8000_0000, 0, 1, STATUS_EVALUATED, 32'sh0002_0000, 1));
    directed.insert(directed.size(),
                    mk(CmdEval, 32'h7fff_ffff, 0, 1, STATUS_EVALUATED, 32'sh0002_0000, 1));
    directed.insert(directed.size(),
                    mk(CmdSet, 32'sh0001_0000, 32'h8000_0000, 1, STATUS_OVERWRITE, 0, 1));
    directed.insert(directed.size(),
                    mk(CmdSet, 32'h8000_0000, 32'h7fff_ffff, 1, STATUS_INSERTED, 0, 2));
    directed.insert(directed.size(),
                    mk(CmdSet, 32'h7fff_ffff, 32'h8000_0000, 1, STATUS_INSERTED, 0, 3));
    directed.insert(directed.size(),
                    mk(CmdEval, 32'h8000_0000, 0, 1, STATUS_EVALUATED, 32'h7fff_ffff, 3));
    directed.insert(directed.size(),
                    mk(CmdEval, 32'h7fff_ffff, 0, 1, STATUS_EVALUATED, 32'h8000_0000, 3));
    directed.insert(directed.size(), mk(CmdEval, 32'sh0001_0000, 0, 0, 0, 0, 0));
    directed.insert(directed.size(), mk(CmdEval, 32'sh0000_0000, 0, 0, 0, 0, 0));
    directed.insert(directed.size(), mk(CmdEval, 32'h8000_0001, 0, 0, 0, 0, 0));
    directed.insert(directed.size(), mk(CmdEval, 32'h7fff_fffe, 0, 0, 0, 0, 0));
    directed.insert(directed.size(), mk(CmdSet, 32'sh0001_0001, 32'h7fff_ffff, 0, 0, 0, 0));
    directed.insert(directed.size(), mk(CmdEval, 32'sh0001_0000, 0, 0, 0, 0, 0));
    directed.insert(directed.size(), mk(CmdEval, 32'sh0001_8000, 0, 0, 0, 0, 0));
    directed.insert(directed.size(), mk(CmdSet, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 0));
    directed.insert(directed.size(), mk(CmdEval, 32'sh0000_8000, 32'hffff_ffff, 0, 0, 0, 0));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_row(directed[i]);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 38 : 0;
      for (int k = 0; k < 317; k++) begin
        logic cmd;
        // set-heavy until the table is full, so the table fills and drops occur
        cmd = ($urandom_range(99) < ((n_keys < MaxKeys) ? 55 : 25)) ? CmdSet : CmdEval;
        send_item(cmd, rand_time(), $urandom);
        if (k == 150) wait_drained();  // sender holds off until all results are in
      end
      wait_drained();
    end

    repeat (300) @(negedge clk_i);
    $display("covered %0d transfers in, %0d results out, %0d interpolated between keys",
             n_sent, n_results, n_interp);
    $display("table held %0d keys at the end, with overwrites and full-table drops", n_keys);
    if (pending_q.size() == 0 && n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
